/* design/jse_pkg.sv */
// Shared types, character constants and helpers for the JSON string escaper.
`timescale 1ns / 1ps
package jse_pkg;

    localparam int MAX_RUN     = 8;
    localparam int IDX_W       = $clog2(MAX_RUN);
    localparam int ESC_MAX     = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LOW_U  = 8'h75;
    localparam logic [7:0] CHAR_LOW_B  = 8'h62;
    localparam logic [7:0] CHAR_LOW_T  = 8'h74;
    localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_LOW_R  = 8'h72;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;

    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CTRL_END = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // One item's complete output run, queued between front and back.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] seq;
        logic [IDX_W-1:0]        last_idx;
    } run_desc_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = CHAR_ZERO + {4'd0, nib};
        end else begin
            res = CHAR_UP_A + {4'd0, nib - 4'd10};
        end
        return res;
    endfunction

endpackage

/* design/jse_classify.sv */
// Front end: classifies one input item and builds its output run.
`timescale 1ns / 1ps
module jse_classify (
    input  jse_pkg::in_item_t  item,
    output jse_pkg::run_desc_t desc
);
    import jse_pkg::*;

    logic [ESC_MAX-1:0][7:0] esc;
    logic [2:0]              esc_len;
    logic [7:0]              short_code;
    logic [2:0]              off;

    always_comb begin
        short_code = 8'd0;
        case (item.data_byte)
            CODE_BS:     short_code = CHAR_LOW_B;
            CODE_TAB:    short_code = CHAR_LOW_T;
            CODE_LF:     short_code = CHAR_LOW_N;
            CODE_FF:     short_code = CHAR_LOW_F;
            CODE_CR:     short_code = CHAR_LOW_R;
            CHAR_QUOTE:  short_code = CHAR_QUOTE;
            CHAR_BSLASH: short_code = CHAR_BSLASH;
            CHAR_SLASH:  short_code = CHAR_SLASH;
            default:     short_code = 8'd0;
        endcase

        esc = '0;
        if (short_code != 8'd0) begin
            esc[0]  = CHAR_BSLASH;
            esc[1]  = short_code;
            esc_len = 3'd2;
        end else if (item.data_byte < CTRL_END) begin
            esc[0]  = CHAR_BSLASH;
            esc[1]  = CHAR_LOW_U;
            esc[2]  = CHAR_ZERO;
            esc[3]  = CHAR_ZERO;
            esc[4]  = hex_char(item.data_byte[7:4]);
            esc[5]  = hex_char(item.data_byte[3:0]);
            esc_len = 3'd6;
        end else begin
            esc[0]  = item.data_byte;
            esc_len = 3'd1;
        end
    end

    always_comb begin
        desc = '0;
        off  = {2'd0, item.first_byte};
        if (item.empty_string) begin
            desc.seq[0]   = CHAR_QUOTE;
            desc.seq[1]   = CHAR_QUOTE;
            desc.last_idx = IDX_W'(1);
        end else begin
            if (item.first_byte) begin
                desc.seq[0] = CHAR_QUOTE;
            end
            for (int k = 0; k < ESC_MAX; k++) begin
                if (3'(k) < esc_len) begin
                    desc.seq[IDX_W'(k) + IDX_W'(off)] = esc[k];
                end
            end
            if (item.last_byte) begin
                desc.seq[IDX_W'(off) + IDX_W'(esc_len)] = CHAR_QUOTE;
            end
            // run length is off + esc_len + last; index of final byte is one less
            desc.last_idx = IDX_W'(off) + IDX_W'(esc_len) + IDX_W'(item.last_byte)
                            - IDX_W'(1);
        end
    end

endmodule

/* design/jse_queue.sv */
// Short queue of output runs between the front and back ends.
`timescale 1ns / 1ps
module jse_queue #(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  jse_pkg::run_desc_t wr_data,
    output logic               rd_valid,
    input  logic               rd_pop,
    output jse_pkg::run_desc_t rd_data
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_desc_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/jse_serializer.sv */
// Back end: walks the head run into the output register one byte per cycle while m_ready does not stall it.
`timescale 1ns / 1ps
module jse_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  jse_pkg::run_desc_t  head,
    output logic                head_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output jse_pkg::out_item_t  m_data
);
    import jse_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic             load;
    logic             at_end;

    assign load    = !out_valid_reg || m_ready;
    assign at_end  = (idx_reg == head.last_idx);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        head_pop       = 1'b0;
        if (load) begin
            out_valid_next = head_valid;
            if (head_valid) begin
                out_data_next.out_byte = head.seq[idx_reg];
                out_data_next.run_last = at_end;
                if (at_end) begin
                    head_pop = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

/* design/json_string_escaper.sv */
// Top level of the JSON string escaper: front classifier, run queue, serializer.
`timescale 1ns / 1ps
// Usage:
//   s_valid/s_ready/s_data carry one string byte per item with first/last
//   marks, or an empty-string mark. m_valid/m_ready/m_data carry the quoted,
//   escaped text one byte per item; run_last flags the final byte of the run
//   produced by one input item (1 to 8 bytes).
// Path: an accepted item is written into the run queue, and its first output
//   byte is loaded from the queue head into the output register once the runs ahead of it have drained.
// Throughput: the serializer emits one byte per cycle while m_ready is high,
//   so an item that expands to n bytes holds the back end until all n are
//   sent. Plain bytes sustain one item per cycle with m_ready high; escapes
//   and quotes stall the input once the QUEUE_DEPTH-entry run queue fills.
// Reset: aresetn (synchronous, active low) empties the queue and the output
//   register; s_ready is high once reset is released.
// Receiver stall: with m_ready low the output byte holds, the serializer
//   stops, and s_ready drops once the queue is full.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jse_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output jse_pkg::out_item_t m_data
);
    import jse_pkg::*;

    run_desc_t front_desc;
    run_desc_t head_desc;
    logic      head_valid;
    logic      head_pop;

    jse_classify u_classify (
        .item (s_data),
        .desc (front_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_desc),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_data  (head_desc)
    );

    jse_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head_desc),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* design/jse_checker.sv */
// Port-level checker for the JSON string escaper, bound to the top level.
`timescale 1ns / 1ps
module jse_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input jse_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input jse_pkg::out_item_t m_data
);
    import jse_pkg::*;

    // waiting input item holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

    // stalled output item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output item changed while stalled");

    // control bytes are always escaped, never emitted raw
    a_no_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_byte >= CTRL_END)
        else $error("raw control byte on output");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/tb_json_string_escaper.sv */
// Self-checking testbench for json_string_escaper: directed table, then random strings.
`timescale 1ns / 1ps
module tb_json_string_escaper;
    import jse_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 8;
    localparam int MAX_CYCLES  = 200000;
    localparam int PHASE_ITEMS = 103;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        in_item_t item;
        string    want;  // literal output text; empty string means use the predictor
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t expected_text[$];
    out_item_t next_expected;
    dir_row_t  dir_rows[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        error_count    = 0;
    int        cycle_count    = 0;
    string     hex_digits     = "0123456789ABCDEF";

    json_string_escaper u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("json_string_escaper verification failed");
            $finish;
        end
    end

    // Escaped, quoted text for one input item, queued as output items.
    task automatic predict_escaped(input in_item_t it);
        logic [7:0] run[$];
        logic [7:0] short_code;
        out_item_t  o;
        run = {};
        short_code = 8'h00;
        if (it.empty_string) begin
            run.push_back(CHAR_QUOTE);
            run.push_back(CHAR_QUOTE);
        end else begin
            if (it.first_byte) run.push_back(CHAR_QUOTE);
            case (it.data_byte)
                CODE_BS:     short_code = CHAR_LOW_B;
                CODE_TAB:    short_code = CHAR_LOW_T;
                CODE_LF:     short_code = CHAR_LOW_N;
                CODE_FF:     short_code = CHAR_LOW_F;
                CODE_CR:     short_code = CHAR_LOW_R;
                CHAR_QUOTE:  short_code = CHAR_QUOTE;
                CHAR_BSLASH: short_code = CHAR_BSLASH;
                CHAR_SLASH:  short_code = CHAR_SLASH;
                default:     short_code = 8'h00;
            endcase
            if (short_code != 8'h00) begin
                run.push_back(CHAR_BSLASH);
                run.push_back(short_code);
            end else if (it.data_byte < CTRL_END) begin
                run.push_back(CHAR_BSLASH);
                run.push_back(CHAR_LOW_U);
                run.push_back(CHAR_ZERO);
                run.push_back(CHAR_ZERO);
                run.push_back(hex_digits[it.data_byte[7:4]]);
                run.push_back(hex_digits[it.data_byte[3:0]]);
            end else begin
                run.push_back(it.data_byte);
            end
            if (it.last_byte) run.push_back(CHAR_QUOTE);
        end
        for (int k = 0; k < run.size(); k++) begin
            o.out_byte = run[k];
            o.run_last = (k == run.size() - 1);
            expected_text.push_back(o);
        end
    endtask

    task automatic queue_literal(input string text);
        out_item_t o;
        for (int k = 0; k < text.len(); k++) begin
            o.out_byte = text[k];
            o.run_last = (k == text.len() - 1);
            expected_text.push_back(o);
        end
    endtask

    function automatic dir_row_t dir_row(input logic [7:0] data, input logic opens,
                                         input logic closes, input logic no_bytes,
                                         input string want);
        dir_row_t r;
        r.item.data_byte    = data;
        r.item.first_byte   = opens;
        r.item.last_byte    = closes;
        r.item.empty_string = no_bytes;
        r.want              = want;
        return r;
    endfunction

    // Byte mix weighted toward control codes and characters that need escaping.
    function automatic logic [7:0] random_text_byte();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            b = 8'($urandom_range(0, 31));
        end else if (pick < 40) begin
            case ($urandom_range(0, 2))
                0:       b = CHAR_QUOTE;
                1:       b = CHAR_BSLASH;
                default: b = CHAR_SLASH;
            endcase
        end else if (pick < 80) begin
            b = 8'($urandom_range(32, 127));
        end else begin
            b = 8'($urandom_range(128, 255));
        end
        return b;
    endfunction

    task automatic send_item(input in_item_t it, input string want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (want.len() == 0) predict_escaped(it);
        else queue_literal(want);
    endtask

    // Hold the sender off until every queued output has come back.
    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                $error("unexpected output item: out_byte=%h run_last=%b",
                       m_data.out_byte, m_data.run_last);
                error_count++;
            end else begin
                next_expected = expected_text.pop_front();
                if (m_data.out_byte !== next_expected.out_byte) begin
                    $error("out_byte: expected %h, got %h",
                           next_expected.out_byte, m_data.out_byte);
                    error_count++;
                end
                if (m_data.run_last !== next_expected.run_last) begin
                    $error("run_last: expected %b, got %b",
                           next_expected.run_last, m_data.run_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int       sent;
        int       len;
        in_item_t it;

        dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b0, 1'b1, "\"\""));
        dir_rows.push_back(dir_row(8'hFF, 1'b1, 1'b1, 1'b1, "\"\""));
        dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b1, 1'b0, "\"\\u0000\""));
        dir_rows.push_back(dir_row(8'h61, 1'b1, 1'b1, 1'b0, "\"a\""));
        dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CODE_BS, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CODE_TAB, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CODE_LF, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CODE_FF, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CODE_CR, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h0B, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h1F, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h01, 1'b1, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CHAR_QUOTE, 1'b0, 1'b1, 1'b0, ""));
        dir_rows.push_back(dir_row(CHAR_BSLASH, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CHAR_SLASH, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(CTRL_END, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h7F, 1'b0, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h80, 1'b1, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h7E, 1'b0, 1'b1, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h1F, 1'b1, 1'b1, 1'b0, ""));
        // quotes on marks in mid-string
        dir_rows.push_back(dir_row(8'h41, 1'b1, 1'b0, 1'b0, ""));
        dir_rows.push_back(dir_row(8'h42, 1'b0, 1'b1, 1'b0, ""));

        send_idle_pct  = 13;
        recv_stall_pct = 84;
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            drain_outputs();
            case (phase)
                0: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 84;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 13;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 15) begin
                    // noise: any marks, including missing and repeated ones
                    it = 11'($urandom);
                    send_item(it, "");
                    sent++;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                    if (len == 0) begin
                        it.data_byte    = 8'($urandom);
                        it.first_byte   = 1'($urandom);
                        it.last_byte    = 1'($urandom);
                        it.empty_string = 1'b1;
                        send_item(it, "");
                        sent++;
                    end else begin
                        for (int k = 0; k < len; k++) begin
                            it.data_byte    = random_text_byte();
                            it.first_byte   = (k == 0);
                            it.last_byte    = (k == len - 1);
                            it.empty_string = 1'b0;
                            send_item(it, "");
                        end
                        sent += len;
                    end
                end
            end
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_text.size() == 0) begin
            $display("json_string_escaper verification clean");
        end else begin
            $display("json_string_escaper verification failed");
        end
        $finish;
    end

endmodule

/* json_string_escaper.f */
design/jse_pkg.sv
design/jse_classify.sv
design/jse_queue.sv
design/jse_serializer.sv
design/json_string_escaper.sv
design/jse_checker.sv
sim/tb_json_string_escaper.sv
